FILE: sv/tdpt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division prime test block.
// ---------------------------------------------------------------------------
package tdpt_pkg;

  localparam int unsigned FactorW = 16;
  localparam int unsigned OutTdataW = 24;  // is_prime + factor, byte padded

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture candidate, divisor := 2
    logic div_start;  // clear remainder, bit index := msb
    logic div_step;   // one restoring remainder step
    logic next_d;     // divisor += 1, square updated
  } tdpt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic x_lt2;      // candidate below two
    logic sq_gt_x;    // divisor squared exceeds candidate
    logic div_last;   // current step handles bit 0
    logic rem_zero;   // remainder is zero
  } tdpt_sts_t;

endpackage : tdpt_pkg
`default_nettype wire

FILE: sv/tdpt_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdpt_dp
// Datapath: candidate, trial divisor with running square, and a bit-serial
// remainder unit taking one candidate bit per cycle.
// ---------------------------------------------------------------------------
module tdpt_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [WIDTH-1:0]             candidate_i,
  input  wire tdpt_pkg::tdpt_cmd_t          cmd_i,
  output tdpt_pkg::tdpt_sts_t               sts_o,
  output logic [tdpt_pkg::FactorW-1:0]      divisor_o
);
  import tdpt_pkg::*;

  localparam int unsigned DW  = (WIDTH + 1) / 2 + 1;
  localparam int unsigned SQW = WIDTH + 2;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned CW  = $clog2(WIDTH);

  logic [WIDTH-1:0] x_q;
  logic [DW-1:0]    d_q;
  logic [SQW-1:0]   sq_q;
  logic [RW-1:0]    rem_q;
  logic [CW-1:0]    cnt_q;

  logic [RW-1:0]       rem_sh;
  logic [RW-1:0]       d_ext;
  logic [DW+FactorW-1:0] d_wide;

  assign rem_sh = {rem_q[RW-2:0], x_q[cnt_q]};
  assign d_ext  = RW'(d_q);
  assign d_wide = (DW + FactorW)'(d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CW'(WIDTH - 1);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= candidate_i;
      d_q  <= DW'(2);
      sq_q <= SQW'(4);
    end else if (cmd_i.next_d) begin
      d_q  <= d_q + 1'b1;
      sq_q <= sq_q + SQW'({d_q, 1'b1});
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= (rem_sh >= d_ext) ? rem_sh - d_ext : rem_sh;
    end
  end

  assign sts_o.x_lt2    = (x_q < WIDTH'(2));
  assign sts_o.sq_gt_x  = (sq_q > SQW'(x_q));
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.rem_zero = (rem_q == '0);
  assign divisor_o      = d_wide[FactorW-1:0];

endmodule : tdpt_dp
`default_nettype wire

FILE: sv/tdpt_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences bound check, remainder and divisor advance per item.
// ---------------------------------------------------------------------------
module tdpt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 out_free_i,
  output logic                      push_o,
  output logic                      prime_o,
  output logic                      has_factor_o,
  input  wire tdpt_pkg::tdpt_sts_t  sts_i,
  output tdpt_pkg::tdpt_cmd_t       cmd_o
);
  import tdpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   prime_q;
  logic   has_factor_q;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign push_o       = (state_q == ST_DONE) && out_free_i;
  assign prime_o      = prime_q;
  assign has_factor_o = has_factor_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:  cmd_o.load      = in_valid_i;
      ST_CHECK: cmd_o.div_start = !sts_i.x_lt2 && !sts_i.sq_gt_x;
      ST_DIV:   cmd_o.div_step  = 1'b1;
      ST_TEST:  cmd_o.next_d    = !sts_i.rem_zero;
      ST_DONE:  cmd_o           = '0;
      default:  cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prime_q      <= 1'b0;
      has_factor_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          priority if (sts_i.x_lt2) begin
            prime_q      <= 1'b0;
            has_factor_q <= 1'b0;
            state_q      <= ST_DONE;
          end else if (sts_i.sq_gt_x) begin
            prime_q      <= 1'b1;
            has_factor_q <= 1'b0;
            state_q      <= ST_DONE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (sts_i.div_last) begin
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (sts_i.rem_zero) begin
            prime_q      <= 1'b0;
            has_factor_q <= 1'b1;
            state_q      <= ST_DONE;
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule : tdpt_ctrl
`default_nettype wire

FILE: sv/trial_division_prime_test_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// trial_division_prime_test_top
// Trial-division primality test of one unsigned word per input word.
// ---------------------------------------------------------------------------
// Input stream s_axis: one candidate per word, low WIDTH bits of tdata.
// Output stream m_axis: one result word per candidate; bit 0 is_prime,
// bits 16:1 the smallest divisor (0 when prime or below two).
// Divisors 2, 3, ... are tried while d*d <= candidate; the square is kept
// by adding 2d+1, so no multiplier is used. Each remainder is formed by a
// bit-serial restoring unit, one candidate bit per cycle.
// Per item: a bound check, then for each trial divisor a remainder pass
// over every candidate bit and a test, then the hand-off to the output;
// the worst case is a prime near 2**WIDTH. The remainder unit sets the
// run time. One item is in work at a time.
// The result sits in an output register; the next candidate is accepted
// while it waits. If the receiver stalls, a finished item waits in the
// controller until the register frees, and no new word is taken meanwhile.
// Reset clears the controller and the output valid flag; no state is
// carried between items.
// ---------------------------------------------------------------------------
module trial_division_prime_test_top #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [WIDTH-1:0] candidate, zero padded to bytes
  input  wire logic [((WIDTH + 7) / 8) * 8 - 1:0]  s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [0] is_prime, [16:1] smallest_factor, [23:17] zero
  output logic [tdpt_pkg::OutTdataW-1:0]           m_axis_tdata_o
);
  import tdpt_pkg::*;

  tdpt_cmd_t            cmd;
  tdpt_sts_t            sts;
  logic [FactorW-1:0]   divisor;
  logic                 push;
  logic                 prime;
  logic                 has_factor;
  logic                 out_free;
  logic                 out_valid_q;
  logic                 out_prime_q;
  logic [FactorW-1:0]   out_factor_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  tdpt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .out_free_i   (out_free),
    .push_o       (push),
    .prime_o      (prime),
    .has_factor_o (has_factor),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  tdpt_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (s_axis_tdata_i[WIDTH-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .divisor_o   (divisor)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_prime_q  <= prime;
      out_factor_q <= has_factor ? divisor : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'({out_factor_q, out_prime_q});

  a_push_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || m_axis_tready_i))
    else $error("result pushed over an unread word");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second word accepted while item in work");

  a_prime_no_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[16:1] == '0))
    else $error("prime result carries a factor");

  a_push_not_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !s_axis_tready_o)
    else $error("result pushed while controller idle");

endmodule : trial_division_prime_test_top
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trial-division prime test block.
// ---------------------------------------------------------------------------
// Candidates go in on s_axis; the bench computes the prime flag and smallest
// divisor of each accepted word by its own trial division and compares every
// result word on m_axis with the oldest outstanding verdict. Directed tests
// cover values below two, the edges of the 32-bit range, known primes and
// perfect squares (most hit the loop bound exactly); random candidates follow, drawn
// so that the divisor search stays short enough for a bounded run. Both
// sides stall in random bursts except during the final stretch.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CandW       = 32;
  localparam int unsigned TrialBudget = 250;   // divisors tried, random part
  localparam int unsigned RandItems   = 100;
  localparam int unsigned CalmItems   = 25;

  typedef struct packed {
    logic [6:0]             padding;
    logic [15:0]            factor;
    logic                   is_prime;
  } verdict_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic [CandW-1:0]       s_axis_tdata_i  = '0;
  logic                   m_axis_tready_i = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [tdpt_pkg::OutTdataW-1:0] m_axis_tdata_o;

  verdict_t               pending_verdicts[$];
  int unsigned            failures = 0;
  bit                     calm     = 1'b0;
  int unsigned            stall_left = 0;

  trial_division_prime_test_top #(
    .WIDTH (CandW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // smallest divisor by trial division; trials counts divisors tried
  function automatic verdict_t classify_candidate(input logic [CandW-1:0] cand,
                                                  output int unsigned trials);
    logic [63:0] x;
    logic [63:0] d;
    verdict_t    v;
    bit          found;
    x          = 64'(cand);
    d          = 64'd2;
    v          = '0;
    v.is_prime = (x >= 64'd2);
    trials     = 0;
    found      = 1'b0;
    if (v.is_prime) begin
      while (!found && d <= x / d) begin
        trials++;
        if (x % d == 64'd0) begin
          v.factor   = d[15:0];
          v.is_prime = 1'b0;
          found      = 1'b1;
        end
        d++;
      end
    end
    return v;
  endfunction

  task automatic send_candidate(input logic [CandW-1:0] cand);
    int unsigned trials;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cand;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_verdicts.push_back(classify_candidate(cand, trials));
  endtask

  // receiver: stalls in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = verdict_t'(m_axis_tdata_o);
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.is_prime !== want.is_prime) begin
          $error("is_prime: expected %0d, got %0d", want.is_prime, got.is_prime);
          failures++;
        end
        if (got.factor !== want.factor) begin
          $error("smallest_factor: expected %0d, got %0d", want.factor, got.factor);
          failures++;
        end
        if (got.padding !== want.padding) begin
          $error("padding: expected %h, got %h", want.padding, got.padding);
          failures++;
        end
      end
    end
  end

  task automatic test_below_two();
    send_candidate(32'd0);
    send_candidate(32'd1);
    send_candidate(32'd2);
    send_candidate(32'd3);
    send_candidate(32'd4);
  endtask

  task automatic test_field_extremes();
    send_candidate(32'hFFFF_FFFF);
    send_candidate(32'hFFFF_FFFE);
    send_candidate(32'h8000_0000);
    send_candidate(32'h5555_5555);
    send_candidate(32'hAAAA_AAAA);
    send_candidate(32'h0001_0000);
  endtask

  task automatic test_known_primes();
    send_candidate(32'd5);
    send_candidate(32'd65521);
    send_candidate(32'd1000003);
    send_candidate(32'd1048573);
  endtask

  // perfect squares; all but the last have no smaller factor, so the last trial hits the bound
  task automatic test_square_bound();
    send_candidate(32'd9);
    send_candidate(32'd25);
    send_candidate(32'd961);
    send_candidate(32'd63001);
    send_candidate(32'd4294836225);
  endtask

  function automatic logic [CandW-1:0] draw_candidate();
    logic [CandW-1:0] cand;
    int unsigned      trials;
    int unsigned      a;
    do begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cand = $urandom();
        4, 5, 6:    cand = $urandom_range(0, 2000);
        7, 8:       cand = $urandom_range(0, 131071);
        default: begin
          a    = $urandom_range(2, 240);
          cand = a * $urandom_range(a, 32'hFFFF_FFFF / a);
        end
      endcase
      void'(classify_candidate(cand, trials));
    end while (trials > TrialBudget);
    return cand;
  endfunction

  task automatic test_random_candidates();
    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i == RandItems - CalmItems) calm = 1'b1;
      send_candidate(draw_candidate());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_below_two();
    test_field_extremes();
    test_known_primes();
    test_square_bound();
    test_random_candidates();
    s_axis_tvalid_i <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule : tb_top
`default_nettype wire
